// ===== sv/mrw_pkg.sv =====
// Package for the Miller-Rabin witness test: widths and controller states.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package mrw_pkg;
  localparam int NUM_WIDTH_DEF = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_SHIFT,
    ST_RED_A,
    ST_POW_MUL,
    ST_POW_SQ,
    ST_CHECK,
    ST_SQ,
    ST_SQ_CHECK,
    ST_DONE,
    ST_OUT
  } state_t;

  // Multiply-modulo operand selection.
  typedef enum logic [1:0] {
    MM_RED_A,
    MM_ACC_SQ,
    MM_SQ_SQ,
    MM_B_B
  } mm_sel_t;

  typedef struct packed {
    logic    load;
    logic    shift_d;
    logic    mm_start;
    mm_sel_t mm_sel;
    logic    e_shift;
  } ctrl_cmd_t;

  typedef struct packed {
    logic d_odd;
    logic mm_done;
    logic e_zero;
    logic e_lsb;
    logic small_n;
    logic small_comp;
    logic b_pass;
    logic b_is_nm1;
    logic r_left;
  } ctrl_sts_t;
endpackage

// ===== sv/mrw_mulmod.sv =====
// Serial multiply-modulo unit: one product, then a restoring reduction of one bit a cycle.
// Self-contained; instantiated by the datapath.
`timescale 1ns / 1ps
module mrw_mulmod #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] x,
  input  logic [W-1:0] y,
  input  logic [W-1:0] m,
  output logic         done,
  output logic [W-1:0] res
);
  localparam int CW = $clog2(2 * W + 1);

  logic [2*W-1:0] prod;
  logic [W:0]     rem;
  logic [CW-1:0]  cnt;
  logic           busy;
  logic           mulph;
  logic [W+1:0]   trial;

  // Shift in the next product bit and subtract the modulus if it fits.
  assign trial = {rem, prod[2*W-1]} - {2'b00, m};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        mulph <= 1'b1;
      end else if (busy && mulph) begin
        mulph <= 1'b0;
        prod  <= x * y;
        rem   <= '0;
        cnt   <= CW'(2 * W);
      end else if (busy) begin
        if (!trial[W+1]) rem <= trial[W:0];
        else rem <= {rem[W-1:0], prod[2*W-1]};
        prod <= {prod[2*W-2:0], 1'b0};
        cnt  <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res = rem[W-1:0];
endmodule

// ===== sv/mrw_datapath.sv =====
// Datapath of the witness test: operand registers, exponent, square counter.
// Depends on mrw_pkg and mrw_mulmod.
`timescale 1ns / 1ps
module mrw_datapath #(
  parameter int W = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [W-1:0]      cand_in,
  input  logic [W-1:0]      wit_in,
  input  mrw_pkg::ctrl_cmd_t cmd,
  output mrw_pkg::ctrl_sts_t sts
);
  localparam int RW = $clog2(W + 1);

  logic [W-1:0]  n, a, d, acc, sq;
  logic [RW-1:0] r;
  logic [W-1:0]  mx, my, mres;
  logic          mdone;
  logic [W-1:0]  nm1;

  assign nm1 = n - 1'b1;

  // Operand select for the shared multiply-modulo unit.
  always_comb begin
    unique case (cmd.mm_sel)
      mrw_pkg::MM_RED_A:  begin mx = a;   my = W'(1); end
      mrw_pkg::MM_ACC_SQ: begin mx = acc; my = sq;    end
      mrw_pkg::MM_SQ_SQ:  begin mx = sq;  my = sq;    end
      default:            begin mx = acc; my = acc;   end
    endcase
  end

  mrw_mulmod #(.W(W)) u_mm (
    .clk(clk), .rst(rst), .start(cmd.mm_start),
    .x(mx), .y(my), .m(n), .done(mdone), .res(mres)
  );

  // Operand and loop registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n   <= cand_in;
      a   <= wit_in;
      d   <= cand_in - 1'b1;
      r   <= '0;
      acc <= W'(1);
    end
    if (cmd.shift_d) begin
      d <= d >> 1;
      r <= r + 1'b1;
    end
    if (mdone) begin
      unique case (cmd.mm_sel)
        mrw_pkg::MM_RED_A: sq <= mres;
        mrw_pkg::MM_ACC_SQ: acc <= mres;
        mrw_pkg::MM_SQ_SQ: sq <= mres;
        default: begin
          acc <= mres;
          r   <= r - 1'b1;
        end
      endcase
    end
    if (cmd.e_shift) d <= d >> 1;
  end

  assign sts.d_odd      = d[0];
  assign sts.mm_done    = mdone;
  assign sts.e_zero     = (d == '0);
  assign sts.e_lsb      = d[0];
  assign sts.small_n    = (n < W'(4));
  assign sts.small_comp = (n < W'(2));
  assign sts.b_pass     = (acc == W'(1)) || (acc == nm1);
  assign sts.b_is_nm1   = (acc == nm1);
  assign sts.r_left     = (r > RW'(1));
endmodule

// ===== sv/mrw_ctrl.sv =====
// Controller state machine of the witness test: sequences factoring, power and squarings.
// Depends on mrw_pkg.
`timescale 1ns / 1ps
module mrw_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               comp_o,
  output logic               prime_o,
  output logic               final_o,
  output mrw_pkg::ctrl_cmd_t cmd,
  input  mrw_pkg::ctrl_sts_t sts
);
  mrw_pkg::state_t state, state_next;
  logic still_probable, last, comp, comp_next, started;

  // Next state.
  always_comb begin
    state_next = state;
    comp_next  = comp;
    unique case (state)
      mrw_pkg::ST_IDLE: if (in_valid) state_next = mrw_pkg::ST_PREP;
      mrw_pkg::ST_PREP: begin
        if (sts.small_n) begin
          comp_next  = sts.small_comp;
          state_next = mrw_pkg::ST_DONE;
        end else state_next = mrw_pkg::ST_SHIFT;
      end
      mrw_pkg::ST_SHIFT: if (sts.d_odd) state_next = mrw_pkg::ST_RED_A;
      mrw_pkg::ST_RED_A: if (sts.mm_done) state_next = mrw_pkg::ST_POW_MUL;
      mrw_pkg::ST_POW_MUL: begin
        if (sts.e_zero) state_next = mrw_pkg::ST_CHECK;
        else if (!sts.e_lsb || (started && sts.mm_done)) state_next = mrw_pkg::ST_POW_SQ;
      end
      mrw_pkg::ST_POW_SQ: if (started && sts.mm_done) state_next = mrw_pkg::ST_POW_MUL;
      mrw_pkg::ST_CHECK: begin
        if (sts.b_pass) begin
          comp_next = 1'b0; state_next = mrw_pkg::ST_DONE;
        end else if (sts.r_left) state_next = mrw_pkg::ST_SQ;
        else begin
          comp_next = 1'b1; state_next = mrw_pkg::ST_DONE;
        end
      end
      mrw_pkg::ST_SQ: if (started && sts.mm_done) state_next = mrw_pkg::ST_SQ_CHECK;
      mrw_pkg::ST_SQ_CHECK: begin
        if (sts.b_is_nm1) begin
          comp_next = 1'b0; state_next = mrw_pkg::ST_DONE;
        end else if (sts.r_left) state_next = mrw_pkg::ST_SQ;
        else begin
          comp_next = 1'b1; state_next = mrw_pkg::ST_DONE;
        end
      end
      mrw_pkg::ST_DONE: state_next = mrw_pkg::ST_OUT;
      mrw_pkg::ST_OUT: if (!out_stall) state_next = mrw_pkg::ST_IDLE;
      default: state_next = mrw_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd = '0;
    cmd.mm_sel = mrw_pkg::MM_RED_A;
    unique case (state)
      mrw_pkg::ST_IDLE:  cmd.load = in_valid;
      mrw_pkg::ST_SHIFT: cmd.shift_d = !sts.d_odd;
      mrw_pkg::ST_RED_A: cmd.mm_start = !started;
      mrw_pkg::ST_POW_MUL: begin
        cmd.mm_sel   = mrw_pkg::MM_ACC_SQ;
        cmd.mm_start = !sts.e_zero && sts.e_lsb && !started;
      end
      mrw_pkg::ST_POW_SQ: begin
        cmd.mm_sel   = mrw_pkg::MM_SQ_SQ;
        cmd.mm_start = !started;
        cmd.e_shift  = started && sts.mm_done;
      end
      mrw_pkg::ST_SQ: begin
        cmd.mm_sel   = mrw_pkg::MM_B_B;
        cmd.mm_start = !started;
      end
      default: ;
    endcase
  end

  // State register; tracks whether the current multiply has been launched and captures the verdict in ST_DONE.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= mrw_pkg::ST_IDLE;
      started        <= 1'b0;
      still_probable <= 1'b1;
    end else begin
      state <= state_next;
      if (cmd.mm_start) started <= 1'b1;
      else if (sts.mm_done) started <= 1'b0;
      if (state == mrw_pkg::ST_DONE) begin
        prime_o <= still_probable & ~comp;
        comp_o  <= comp;
        final_o <= last;
        still_probable <= last ? 1'b1 : (still_probable & ~comp);
      end
    end
  end

  always_ff @(posedge clk) begin
    comp <= comp_next;
    if (state == mrw_pkg::ST_IDLE && in_valid) last <= in_last;
  end

  assign in_stall  = (state != mrw_pkg::ST_IDLE);
  assign out_valid = (state == mrw_pkg::ST_OUT);
endmodule

// ===== sv/miller_rabin_witness_test.sv =====
// Miller-Rabin witness test, one round per input beat.
// Input beat: candidate, witness, last_witness, on in_valid / in_stall.
// Output beat: witness_shows_composite, probable_prime, verdict_final,
// on out_valid / out_stall; one output beat per input beat, in order.
// The block works on one beat at a time: in_stall is high from the cycle
// after acceptance until its result beat is taken, and the next beat can be
// accepted in the cycle after that. The round factors candidate-1 into
// d * 2^r (one bit a cycle), reduces the witness, runs square-and-multiply
// for witness^d and then up to r-1 squarings. Every modular product goes
// through one shared multiply-modulo unit. Candidates below 4 go from the
// preparation state straight to the done and output states.
// Reset is synchronous: it returns to idle and rearms the probable-prime
// flag. A stalled result beat holds until out_stall drops.
`timescale 1ns / 1ps
module miller_rabin_witness_test #(
  parameter int NUM_WIDTH = mrw_pkg::NUM_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] candidate,
  input  logic [31:0] witness,
  input  logic        last_witness,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        witness_shows_composite,
  output logic        probable_prime,
  output logic        verdict_final
);
  mrw_pkg::ctrl_cmd_t cmd;
  mrw_pkg::ctrl_sts_t sts;

  mrw_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_last(last_witness), .out_valid(out_valid), .out_stall(out_stall),
    .comp_o(witness_shows_composite), .prime_o(probable_prime),
    .final_o(verdict_final), .cmd(cmd), .sts(sts)
  );

  mrw_datapath #(.W(NUM_WIDTH)) u_dp (
    .clk(clk), .rst(rst),
    .cand_in(candidate[NUM_WIDTH-1:0]), .wit_in(witness[NUM_WIDTH-1:0]),
    .cmd(cmd), .sts(sts)
  );
endmodule

// ===== sv/mrw_checker.sv =====
// Port checker for the witness test, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
module mrw_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic witness_shows_composite,
  input logic probable_prime,
  input logic verdict_final
);
  // A composite round never reports probably prime.
  a_comp: assert property (@(posedge clk) disable iff (rst)
    out_valid && witness_shows_composite |-> !probable_prime)
    else $error("composite round reported prime");

  // Only one beat in flight: no input taken while a result is shown.
  a_one: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted during output");

  // An accepted input is not immediately followed by a result.
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid)
    else $error("result too early");

  // Stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid &&
      $stable({witness_shows_composite, probable_prime, verdict_final}))
    else $error("stalled result changed");
endmodule

bind miller_rabin_witness_test mrw_checker u_chk (.*);
